// ----- rtl/sdsh_pkg.sv -----
// ----------------------------------------------------------------------------
// sdsh_pkg
// Shared types and codes of the SD-card SPI host byte sequencer.
// ----------------------------------------------------------------------------
package sdsh_pkg;

  // request codes
  localparam logic [2:0] REQ_INIT     = 3'd0;
  localparam logic [2:0] REQ_WRITE    = 3'd1;
  localparam logic [2:0] REQ_XCH_DONE = 3'd2;
  localparam logic [2:0] REQ_DATA     = 3'd3;
  localparam logic [2:0] REQ_RDY_CHK  = 3'd4;

  // completion status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CARD_ERR = 2'd1;
  localparam logic [1:0] ST_PARM_ERR = 2'd2;
  localparam logic [1:0] ST_BUSY_REJ = 2'd3;

  // sequencer phases
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_WAKE  = 5'd1;
  localparam logic [4:0] PH_ICMD  = 5'd2;
  localparam logic [4:0] PH_IPOLL = 5'd3;
  localparam logic [4:0] PH_READY = 5'd4;
  localparam logic [4:0] PH_WCMD  = 5'd5;
  localparam logic [4:0] PH_R1    = 5'd6;
  localparam logic [4:0] PH_TOKEN = 5'd7;
  localparam logic [4:0] PH_DWAIT = 5'd8;
  localparam logic [4:0] PH_DXCH  = 5'd9;
  localparam logic [4:0] PH_CRC   = 5'd10;
  localparam logic [4:0] PH_DRESP = 5'd11;
  localparam logic [4:0] PH_BUSY  = 5'd12;

  // protocol bytes
  localparam logic [7:0] CMD0_BYTE   = 8'h40;
  localparam logic [7:0] CMD0_CRC    = 8'h95;
  localparam logic [7:0] CMD24_BYTE  = 8'h58;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] DRESP_MASK  = 8'h1F;
  localparam logic [7:0] DRESP_OK    = 8'h05;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;
  localparam logic [7:0] R1_IDLE     = 8'h01;

  // command frames are six bytes long
  localparam int CMD_LEN = 6;
  // CRC trailer is two bytes long
  localparam int CRC_LEN = 2;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_low;
    logic       want_data;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

// ----- rtl/sd_spi_host_sequencer.sv -----
// ----------------------------------------------------------------------------
// sd_spi_host_sequencer
// SD-card SPI-mode host byte sequencer: init, ready check, single-block write.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event transaction: a start
//   request (init, write, ready check), an exchange-done report with the byte
//   the card returned, or a payload data byte. Every accepted transaction
//   yields exactly one result transaction on out_valid/out_ready, telling the
//   SPI shifter whether to exchange a byte (out_tx_valid/out_tx_byte), the
//   chip select level, whether a payload byte is wanted next, and whether the
//   running sequence finished (out_done_res/out_status).
//   Path: an accepted transaction lands in the input register; its result is
//   then computed against the sequencer state and loaded into the result
//   register, which raises out_valid and holds the result until it is taken.
//   Throughput: one transaction per cycle while out_ready stays high; the only
//   loop is the state update of the phase/counter registers.
//   Stall: when out_ready is low the result register holds, the input
//   register still takes one more transaction, then in_ready drops.
//   Reset (rst_n low, synchronous): both stages empty, phase idle, counters
//   and held sector cleared, card deselected.
// ----------------------------------------------------------------------------
module sd_spi_host_sequencer #(
  parameter int BLOCK_BYTES = 512,
  parameter int WAKE_BYTES  = 10,
  parameter int IDLE_POLLS  = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_sector,
  input  logic [15:0] in_block_count,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_valid,
  output logic [7:0]  out_tx_byte,
  output logic        out_chip_select_low,
  output logic        out_want_data,
  output logic        out_done_res,
  output logic [1:0]  out_status
);
  import sdsh_pkg::*;

  // counter must hold block index, wake count and command index
  localparam int BB_W  = $clog2(BLOCK_BYTES);
  localparam int CNT_W = (BB_W > 4) ? BB_W : 4;

  localparam logic [CNT_W-1:0] WAKE_LIM  = CNT_W'(WAKE_BYTES);
  localparam logic [CNT_W-1:0] LAST_IDX  = CNT_W'(BLOCK_BYTES - 1);
  localparam logic [CNT_W-1:0] CMD_LIM   = CNT_W'(CMD_LEN);
  localparam logic [CNT_W-1:0] CRC_LIM   = CNT_W'(CRC_LEN);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [3:0]       POLL_LIM  = 4'(IDLE_POLLS);

  // input stage
  logic        in_vld_r;
  logic [2:0]  req_r;
  logic [31:0] sec_r;
  logic [15:0] cnt_r;
  logic [7:0]  dat_r;
  logic [7:0]  rx_r;

  // sequencer state
  logic [4:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [3:0]       pcnt_r, pcnt_nxt;
  logic [31:0]      shold_r, shold_nxt;
  logic             sel_r, sel_nxt;

  // result stage
  logic out_vld_r;
  res_t res_r, res_nxt;

  logic advance;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= in_req_type;
      sec_r <= in_sector;
      cnt_r <= in_block_count;
      dat_r <= in_data_byte;
      rx_r  <= in_rx_byte;
    end
  end

  // next byte / next state decision
  always_comb begin
    logic [7:0] txb;
    logic       txv;
    logic       want;
    logic       done;
    logic [1:0] st;

    phase_nxt = phase_r;
    bcnt_nxt  = bcnt_r;
    pcnt_nxt  = pcnt_r;
    shold_nxt = shold_r;
    sel_nxt   = sel_r;
    txv       = 1'b0;
    txb       = 8'h00;
    want      = 1'b0;
    done      = 1'b0;
    st        = ST_OK;

    if (req_r == REQ_INIT || req_r == REQ_WRITE || req_r == REQ_RDY_CHK) begin
      if (phase_r != PH_IDLE) begin
        st = ST_BUSY_REJ;
      end else if (req_r == REQ_INIT) begin
        phase_nxt = PH_WAKE;
        sel_nxt   = 1'b0;
        bcnt_nxt  = CNT_ONE;
        txv       = 1'b1;
        txb       = FILL_BYTE;
      end else if (req_r == REQ_RDY_CHK) begin
        phase_nxt = PH_READY;
        sel_nxt   = 1'b0;
        txv       = 1'b1;
        txb       = FILL_BYTE;
      end else if (cnt_r == 16'd0) begin
        done = 1'b1;
        st   = ST_PARM_ERR;
      end else begin
        shold_nxt = sec_r;
        phase_nxt = PH_WCMD;
        sel_nxt   = 1'b1;
        bcnt_nxt  = CNT_ONE;
        txv       = 1'b1;
        txb       = CMD24_BYTE;
      end
    end else if (req_r == REQ_XCH_DONE) begin
      case (phase_r)
        PH_WAKE: begin
          txv = 1'b1;
          if (bcnt_r < WAKE_LIM) begin
            bcnt_nxt = bcnt_r + CNT_ONE;
            txb      = FILL_BYTE;
          end else begin
            phase_nxt = PH_ICMD;
            sel_nxt   = 1'b1;
            bcnt_nxt  = CNT_ONE;
            txb       = CMD0_BYTE;
          end
        end
        PH_ICMD: begin
          txv = 1'b1;
          if (bcnt_r < CMD_LIM) begin
            // argument bytes are zero, last byte carries the fixed CRC
            txb      = (bcnt_r == CMD_LIM - CNT_ONE) ? CMD0_CRC : 8'h00;
            bcnt_nxt = bcnt_r + CNT_ONE;
          end else begin
            phase_nxt = PH_IPOLL;
            pcnt_nxt  = 4'd1;
            txb       = FILL_BYTE;
          end
        end
        PH_IPOLL: begin
          if (rx_r == R1_IDLE || pcnt_r >= POLL_LIM) begin
            phase_nxt = PH_IDLE;
            sel_nxt   = 1'b0;
            done      = 1'b1;
          end else begin
            pcnt_nxt = pcnt_r + 4'd1;
            txv      = 1'b1;
            txb      = FILL_BYTE;
          end
        end
        PH_READY: begin
          // card stays selected after a ready check
          phase_nxt = PH_IDLE;
          sel_nxt   = 1'b1;
          done      = 1'b1;
          st        = (rx_r == FILL_BYTE) ? ST_OK : ST_CARD_ERR;
        end
        PH_WCMD: begin
          txv = 1'b1;
          if (bcnt_r < CMD_LIM) begin
            case (bcnt_r[2:0])
              3'd1:    txb = shold_r[31:24];
              3'd2:    txb = shold_r[23:16];
              3'd3:    txb = shold_r[15:8];
              3'd4:    txb = shold_r[7:0];
              default: txb = FILL_BYTE;
            endcase
            bcnt_nxt = bcnt_r + CNT_ONE;
          end else begin
            phase_nxt = PH_R1;
            txb       = FILL_BYTE;
          end
        end
        PH_R1: begin
          if (rx_r != 8'h00) begin
            phase_nxt = PH_IDLE;
            sel_nxt   = 1'b0;
            done      = 1'b1;
            st        = ST_CARD_ERR;
          end else begin
            phase_nxt = PH_TOKEN;
            txv       = 1'b1;
            txb       = START_TOKEN;
          end
        end
        PH_TOKEN: begin
          phase_nxt = PH_DWAIT;
          bcnt_nxt  = '0;
          want      = 1'b1;
        end
        PH_DXCH: begin
          if (bcnt_r < LAST_IDX) begin
            bcnt_nxt  = bcnt_r + CNT_ONE;
            phase_nxt = PH_DWAIT;
            want      = 1'b1;
          end else begin
            phase_nxt = PH_CRC;
            bcnt_nxt  = CNT_ONE;
            txv       = 1'b1;
            txb       = FILL_BYTE;
          end
        end
        PH_CRC: begin
          if (bcnt_r < CRC_LIM) begin
            bcnt_nxt = bcnt_r + CNT_ONE;
          end else begin
            phase_nxt = PH_DRESP;
          end
          txv = 1'b1;
          txb = FILL_BYTE;
        end
        PH_DRESP: begin
          if ((rx_r & DRESP_MASK) != DRESP_OK) begin
            phase_nxt = PH_IDLE;
            sel_nxt   = 1'b0;
            done      = 1'b1;
            st        = ST_CARD_ERR;
          end else begin
            phase_nxt = PH_BUSY;
            txv       = 1'b1;
            txb       = FILL_BYTE;
          end
        end
        PH_BUSY: begin
          // card holds the line low while programming
          if (rx_r == 8'h00) begin
            txv = 1'b1;
            txb = FILL_BYTE;
          end else begin
            phase_nxt = PH_IDLE;
            sel_nxt   = 1'b0;
            done      = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (req_r == REQ_DATA && phase_r == PH_DWAIT) begin
      phase_nxt = PH_DXCH;
      txv       = 1'b1;
      txb       = dat_r;
    end

    res_nxt.tx_valid        = txv;
    res_nxt.tx_byte         = txb;
    res_nxt.chip_select_low = sel_nxt;
    res_nxt.want_data       = want;
    res_nxt.done_res        = done;
    res_nxt.status          = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bcnt_r  <= '0;
      pcnt_r  <= '0;
      shold_r <= '0;
      sel_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      bcnt_r  <= bcnt_nxt;
      pcnt_r  <= pcnt_nxt;
      shold_r <= shold_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_tx_valid        = res_r.tx_valid;
  assign out_tx_byte         = res_r.tx_byte;
  assign out_chip_select_low = res_r.chip_select_low;
  assign out_want_data       = res_r.want_data;
  assign out_done_res        = res_r.done_res;
  assign out_status          = res_r.status;

  // held result always describes the current state
  a_want_dwait: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.want_data |-> phase_r == PH_DWAIT)
    else $error("want_data without data wait phase");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.done_res |-> phase_r == PH_IDLE)
    else $error("sequence done but phase not idle");

  a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && res_r.status == ST_BUSY_REJ |-> phase_r != PH_IDLE)
    else $error("busy reject while idle");

  a_sel_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> res_r.chip_select_low == sel_r)
    else $error("reported select differs from held level");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(req_r))
    else $error("input stage lost a transaction");

endmodule

// ----- tb/spi_reply_pkg.sv -----
// ----------------------------------------------------------------------------
// spi_reply_pkg
// Reply predictor and scoreboard for the SD-card SPI host byte sequencer.
// Tracks the sequencer phase and counters per accepted event transaction and
// queues the reply that the block must produce for it.
// ----------------------------------------------------------------------------
package spi_reply_pkg;

  import sdsh_pkg::*;

  localparam int SEQ_BLOCK_BYTES = 512;
  localparam int SEQ_WAKE_BYTES  = 10;
  localparam int SEQ_IDLE_POLLS  = 10;
  localparam int REPORT_LIMIT    = 10;

  class spi_reply_board;
    logic [4:0]  phase;
    logic [9:0]  byte_cnt;
    logic [3:0]  poll_cnt;
    logic [31:0] sector_hold;
    logic        sel;

    res_t replies_due[$];

    int n_events;
    int n_replies;
    int n_fail;
    int n_inits;
    int n_blocks;
    int status_tally[4];

    function new();
      phase       = PH_IDLE;
      byte_cnt    = '0;
      poll_cnt    = '0;
      sector_hold = '0;
      sel         = 1'b0;
      n_events    = 0;
      n_replies   = 0;
      n_fail      = 0;
      n_inits     = 0;
      n_blocks    = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    // Advance the sequencer state for one accepted event and queue its reply.
    function void note_event(input logic [2:0] req, input logic [31:0] sec,
                             input logic [15:0] cnt, input logic [7:0] dat,
                             input logic [7:0] rx);
      logic       txv;
      logic [7:0] txb;
      logic       want;
      logic       done;
      logic [1:0] st;
      res_t       r;
      txv  = 1'b0;
      txb  = 8'h00;
      want = 1'b0;
      done = 1'b0;
      st   = ST_OK;
      n_events++;
      if (req == REQ_INIT || req == REQ_WRITE || req == REQ_RDY_CHK) begin
        if (phase != PH_IDLE) begin
          st = ST_BUSY_REJ;
        end else if (req == REQ_INIT) begin
          phase    = PH_WAKE;
          sel      = 1'b0;
          byte_cnt = 10'd1;
          txv      = 1'b1;
          txb      = FILL_BYTE;
        end else if (req == REQ_RDY_CHK) begin
          phase = PH_READY;
          sel   = 1'b0;
          txv   = 1'b1;
          txb   = FILL_BYTE;
        end else if (cnt == 16'h0000) begin
          done = 1'b1;
          st   = ST_PARM_ERR;
        end else begin
          sector_hold = sec;
          phase       = PH_WCMD;
          sel         = 1'b1;
          byte_cnt    = 10'd1;
          txv         = 1'b1;
          txb         = CMD24_BYTE;
        end
      end else if (req == REQ_XCH_DONE) begin
        case (phase)
          PH_WAKE: begin
            txv = 1'b1;
            if (byte_cnt < SEQ_WAKE_BYTES) begin
              byte_cnt++;
              txb = FILL_BYTE;
            end else begin
              phase    = PH_ICMD;
              sel      = 1'b1;
              byte_cnt = 10'd1;
              txb      = CMD0_BYTE;
            end
          end
          PH_ICMD: begin
            txv = 1'b1;
            if (byte_cnt < CMD_LEN) begin
              txb = (byte_cnt == CMD_LEN - 1) ? CMD0_CRC : 8'h00;
              byte_cnt++;
            end else begin
              phase    = PH_IPOLL;
              poll_cnt = 4'd1;
              txb      = FILL_BYTE;
            end
          end
          PH_IPOLL: begin
            if (rx == R1_IDLE || poll_cnt >= SEQ_IDLE_POLLS) begin
              phase = PH_IDLE;
              sel   = 1'b0;
              done  = 1'b1;
              st    = ST_OK;
              n_inits++;
            end else begin
              poll_cnt++;
              txv = 1'b1;
              txb = FILL_BYTE;
            end
          end
          PH_READY: begin
            // card stays selected after a ready check
            phase = PH_IDLE;
            sel   = 1'b1;
            done  = 1'b1;
            st    = (rx == FILL_BYTE) ? ST_OK : ST_CARD_ERR;
          end
          PH_WCMD: begin
            txv = 1'b1;
            if (byte_cnt < CMD_LEN) begin
              // sector bytes MSB first, then a filler CRC
              if (byte_cnt == CMD_LEN - 1) txb = FILL_BYTE;
              else txb = 8'(sector_hold >> (8 * (4 - int'(byte_cnt))));
              byte_cnt++;
            end else begin
              phase = PH_R1;
              txb   = FILL_BYTE;
            end
          end
          PH_R1: begin
            if (rx != 8'h00) begin
              phase = PH_IDLE;
              sel   = 1'b0;
              done  = 1'b1;
              st    = ST_CARD_ERR;
            end else begin
              phase = PH_TOKEN;
              txv   = 1'b1;
              txb   = START_TOKEN;
            end
          end
          PH_TOKEN: begin
            phase    = PH_DWAIT;
            byte_cnt = '0;
            want     = 1'b1;
          end
          PH_DXCH: begin
            if (byte_cnt + 1 < SEQ_BLOCK_BYTES) begin
              byte_cnt++;
              phase = PH_DWAIT;
              want  = 1'b1;
            end else begin
              phase    = PH_CRC;
              byte_cnt = 10'd1;
              txv      = 1'b1;
              txb      = FILL_BYTE;
            end
          end
          PH_CRC: begin
            if (byte_cnt < CRC_LEN) byte_cnt++;
            else phase = PH_DRESP;
            txv = 1'b1;
            txb = FILL_BYTE;
          end
          PH_DRESP: begin
            if ((rx & DRESP_MASK) != DRESP_OK) begin
              phase = PH_IDLE;
              sel   = 1'b0;
              done  = 1'b1;
              st    = ST_CARD_ERR;
            end else begin
              phase = PH_BUSY;
              txv   = 1'b1;
              txb   = FILL_BYTE;
            end
          end
          PH_BUSY: begin
            if (rx == 8'h00) begin
              txv = 1'b1;
              txb = FILL_BYTE;
            end else begin
              phase = PH_IDLE;
              sel   = 1'b0;
              done  = 1'b1;
              st    = ST_OK;
              n_blocks++;
            end
          end
          default: ;
        endcase
      end else if (req == REQ_DATA && phase == PH_DWAIT) begin
        phase = PH_DXCH;
        txv   = 1'b1;
        txb   = dat;
      end
      if (done || st == ST_BUSY_REJ) status_tally[st]++;
      r.tx_valid        = txv;
      r.tx_byte         = txb;
      r.chip_select_low = sel;
      r.want_data       = want;
      r.done_res        = done;
      r.status          = st;
      replies_due.push_back(r);
    endfunction

    // Compare one accepted reply against the oldest queued one.
    function void check_reply(input res_t got);
      res_t exp_r;
      n_replies++;
      if (replies_due.size() == 0) begin
        n_fail++;
        if (n_fail <= REPORT_LIMIT)
          $display("reply %0d arrived with nothing outstanding", n_replies);
        return;
      end
      exp_r = replies_due.pop_front();
      if (got.tx_valid !== exp_r.tx_valid || got.tx_byte !== exp_r.tx_byte ||
          got.chip_select_low !== exp_r.chip_select_low ||
          got.want_data !== exp_r.want_data || got.done_res !== exp_r.done_res ||
          got.status !== exp_r.status) begin
        n_fail++;
        if (n_fail <= REPORT_LIMIT) begin
          $display("reply %0d mismatch: exp txv=%0d tx=%02h cs=%0d want=%0d done=%0d st=%0d",
                   n_replies, exp_r.tx_valid, exp_r.tx_byte, exp_r.chip_select_low,
                   exp_r.want_data, exp_r.done_res, exp_r.status);
          $display("               got txv=%0d tx=%02h cs=%0d want=%0d done=%0d st=%0d",
                   got.tx_valid, got.tx_byte, got.chip_select_low,
                   got.want_data, got.done_res, got.status);
        end
      end
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the SD-card SPI host byte sequencer.
// A directed prologue hits stray events, reserved request codes, a zero block
// count, starts while busy and both ready check outcomes. Random traffic then
// mostly follows the card protocol (init, ready check, single-block write)
// with random card replies and payload, plus some noise. Every reply is
// checked field by field against a predictor in spi_reply_pkg.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import sdsh_pkg::*;
  import spi_reply_pkg::*;

  localparam int RANDOM_EVENTS = 1430;    // event transactions that do something
  localparam int CYCLE_LIMIT   = 200_000; // far beyond the slowest legal run
  localparam int DRAIN_CYCLES  = 10;      // pipeline is two deep

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [31:0] in_sector = '0;
  logic [15:0] in_block_count = '0;
  logic [7:0]  in_data_byte = '0;
  logic [7:0]  in_rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_tx_valid;
  logic [7:0]  out_tx_byte;
  logic        out_chip_select_low;
  logic        out_want_data;
  logic        out_done_res;
  logic [1:0]  out_status;

  spi_reply_board board;
  bit             no_idle = 1'b0;   // burst mode: neither side idles
  int unsigned    cycle_count = 0;

  always #10 clk = ~clk;

  sd_spi_host_sequencer #(
    .BLOCK_BYTES(SEQ_BLOCK_BYTES),
    .WAKE_BYTES (SEQ_WAKE_BYTES),
    .IDLE_POLLS (SEQ_IDLE_POLLS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_sector          (in_sector),
    .in_block_count     (in_block_count),
    .in_data_byte       (in_data_byte),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_tx_valid       (out_tx_valid),
    .out_tx_byte        (out_tx_byte),
    .out_chip_select_low(out_chip_select_low),
    .out_want_data      (out_want_data),
    .out_done_res       (out_done_res),
    .out_status         (out_status)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle cycles before each transaction on either side.
  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 4);
  endfunction

  // Drive one event transaction, hold it until the handshake, then let the
  // predictor see it. Valid is only dropped when a gap follows, so a
  // back-to-back transaction never lowers and raises valid in one step.
  task automatic push_event(input logic [2:0] req, input logic [31:0] sec,
                            input logic [15:0] cnt, input logic [7:0] dat,
                            input logic [7:0] rx);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_sector      <= sec;
    in_block_count <= cnt;
    in_data_byte   <= dat;
    in_rx_byte     <= rx;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    board.note_event(req, sec, cnt, dat, rx);
  endtask

  // Pick the next transaction from the predicted phase: mostly what a real
  // SPI shifter and card would send, with card replies biased so that long
  // paths (full block write, full init poll, busy polling) are reached.
  task automatic random_event(output bit useful);
    logic [2:0]  req;
    logic [31:0] sec;
    logic [15:0] cnt;
    logic [7:0]  dat;
    logic [7:0]  rx;
    int          pick;
    sec  = $urandom;
    cnt  = 16'($urandom);
    dat  = 8'($urandom);
    rx   = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      // noise: any code, including reserved ones and starts while busy
      req = 3'($urandom_range(0, 7));
    end else begin
      case (board.phase)
        PH_IDLE: begin
          pick = $urandom_range(0, 99);
          if (pick < 25) req = REQ_INIT;
          else if (pick < 45) req = REQ_RDY_CHK;
          else begin
            req = REQ_WRITE;
            if (pick < 52) cnt = '0;
          end
          no_idle = ($urandom_range(0, 3) == 0);
        end
        PH_DWAIT: req = REQ_DATA;
        default: begin
          req = REQ_XCH_DONE;
          case (board.phase)
            PH_IPOLL: if ($urandom_range(0, 5) == 0) rx = R1_IDLE;
            PH_READY: if ($urandom_range(0, 1) == 0) rx = FILL_BYTE;
            PH_R1:    if ($urandom_range(0, 6) != 0) rx = 8'h00;
            PH_DRESP: if ($urandom_range(0, 6) != 0) rx[4:0] = DRESP_OK[4:0];
            PH_BUSY:  if ($urandom_range(0, 4) < 3) rx = 8'h00;
            default: ;
          endcase
        end
      endcase
    end
    // events the block just ignores do not count toward the total
    useful = !(req > REQ_RDY_CHK ||
               (req == REQ_DATA && board.phase != PH_DWAIT) ||
               (req == REQ_XCH_DONE &&
                (board.phase == PH_IDLE || board.phase == PH_DWAIT)));
    push_event(req, sec, cnt, dat, rx);
  endtask

  // Reply side: random back-pressure, check every accepted transaction.
  initial begin
    int   stall;
    res_t got;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.tx_valid        = out_tx_valid;
      got.tx_byte         = out_tx_byte;
      got.chip_select_low = out_chip_select_low;
      got.want_data       = out_want_data;
      got.done_res        = out_done_res;
      got.status          = out_status;
      board.check_reply(got);
    end
  end

  initial begin
    bit useful;
    int n_stim;
    board  = new();
    n_stim = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed prologue ---
    // stray exchange-done and data byte while idle
    push_event(REQ_XCH_DONE, '0, '0, '0, FILL_BYTE);
    push_event(REQ_DATA, '1, '1, 8'hFF, 8'h00);
    // reserved request codes, every field at its maximum
    for (int k = 1; k <= 3; k++) push_event(REQ_RDY_CHK + 3'(k), '1, '1, '1, '1);
    // zero block count: parameter error with no exchange
    push_event(REQ_WRITE, '1, 16'h0000, 8'h00, 8'h00);
    // ready check with a bad answer; a start meanwhile is rejected
    push_event(REQ_RDY_CHK, '0, '0, '0, '0);
    push_event(REQ_INIT, '0, 16'h0001, '0, '0);
    push_event(REQ_XCH_DONE, '0, '0, '0, 8'h00);
    // ready check that passes; card stays selected afterwards
    push_event(REQ_RDY_CHK, '0, '0, '0, '0);
    push_event(REQ_XCH_DONE, '0, '0, '0, FILL_BYTE);
    // write to the top sector, starts while busy, then a bad R1
    push_event(REQ_WRITE, 32'hFFFF_FFFF, 16'h0001, 8'h00, 8'h00);
    push_event(REQ_RDY_CHK, '0, '0, '0, '0);
    push_event(REQ_WRITE, '0, 16'hFFFF, '0, '0);
    repeat (6) push_event(REQ_XCH_DONE, '0, '0, '0, 8'h00);
    push_event(REQ_XCH_DONE, '0, '0, '0, FILL_BYTE);

    // --- random protocol traffic ---
    while (n_stim < RANDOM_EVENTS) begin
      random_event(useful);
      if (useful) n_stim++;
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    // drain: everything outstanding, then a few cycles for stray replies
    while (board.replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transactions in, %0d replies checked; %0d inits, %0d blocks written",
             board.n_events, board.n_replies, board.n_inits, board.n_blocks);
    $display("sequence ends: ok %0d, card error %0d, parameter error %0d; busy rejects %0d",
             board.status_tally[ST_OK], board.status_tally[ST_CARD_ERR],
             board.status_tally[ST_PARM_ERR], board.status_tally[ST_BUSY_REJ]);
    if (board.n_fail == 0 && board.replies_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sd_spi_host_sequencer.f -----
rtl/sdsh_pkg.sv
rtl/sd_spi_host_sequencer.sv
tb/spi_reply_pkg.sv
tb/tb_top.sv
